// ===== src/nested_tlv_stream_parser_assert.svh =====
// assertion macros used by the parser core (ntlv_core)
// expects signals named aclk and aresetn in the scope of use
`ifndef NESTED_TLV_STREAM_PARSER_ASSERT_SVH
`define NESTED_TLV_STREAM_PARSER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define NTLV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define NTLV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ntlv_pkg.sv =====
// shared constants and types of the nested tlv stream parser
// no dependencies
`timescale 1ns / 1ps

package ntlv_pkg;

    // nesting limit of the hardware
    localparam int unsigned MAX_DEPTH = 15;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned LIM_W   = 4;
    localparam int unsigned TDATA_W = 144;

    // reset value of the depth limit register
    localparam logic [LIM_W-1:0] DEPTH_LIMIT_RST = 4'd15;
    // greatest identifier or size length in bytes
    localparam logic [3:0] MAX_FIELD_LEN = 4'd8;

    // event kinds
    localparam logic [KIND_W-1:0] EV_START = 3'd0;
    localparam logic [KIND_W-1:0] EV_DATA  = 3'd1;
    localparam logic [KIND_W-1:0] EV_END   = 3'd2;
    localparam logic [KIND_W-1:0] EV_STRAY = 3'd3;
    localparam logic [KIND_W-1:0] EV_ERROR = 3'd4;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TAG    = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    // one parser event
    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [VAL_W-1:0]   tag;
        logic [VAL_W-1:0]   length;
        logic [LEVEL_W-1:0] level;
        logic [BYTE_W-1:0]  data;
    } event_t;

endpackage

// ===== src/ntlv_in_stage.sv =====
// input register stage of the nested tlv stream parser
// depends on ntlv_pkg
`timescale 1ns / 1ps

module ntlv_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ntlv_pkg::BYTE_W-1:0] s_tdata,   // stream_byte
    input  logic                        take,
    output logic                        hold_valid,
    output logic [ntlv_pkg::BYTE_W-1:0] hold_byte
);

    logic                        valid_reg;
    logic [ntlv_pkg::BYTE_W-1:0] byte_reg;

    // free when empty or when the held beat is consumed this cycle
    assign s_tready   = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // held beat
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// ===== src/ntlv_core.sv =====
// parse state and event decode of the nested tlv stream parser
// depends on ntlv_pkg and nested_tlv_stream_parser_assert.svh
`timescale 1ns / 1ps
`include "nested_tlv_stream_parser_assert.svh"

module ntlv_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [ntlv_pkg::BYTE_W-1:0] byte_i,
    input  logic                        cfg_we,
    input  logic [ntlv_pkg::LIM_W-1:0]  cfg_wdata,
    output ntlv_pkg::event_t            ev
);

    logic [ntlv_pkg::LIM_W-1:0]   depth_limit_reg;
    logic [2:0]                   phase_reg, phase_next;
    logic [3:0]                   tag_len_reg, tag_len_next;
    logic [3:0]                   len_len_reg, len_len_next;
    logic [3:0]                   byte_idx_reg, byte_idx_next;
    logic [ntlv_pkg::VAL_W-1:0]   tag_acc_reg, tag_acc_next;
    logic [ntlv_pkg::VAL_W-1:0]   len_acc_reg, len_acc_next;
    logic [ntlv_pkg::VAL_W-1:0]   remain_reg, remain_next;
    logic [ntlv_pkg::LEVEL_W-1:0] open_reg, open_next;

    logic [ntlv_pkg::LIM_W-1:0]   eff_limit;
    logic [3:0]                   idl, szl;
    logic [3:0]                   idx_inc;
    logic [ntlv_pkg::VAL_W-1:0]   byte_shift;
    logic [ntlv_pkg::VAL_W-1:0]   tag_merged, len_merged;
    logic [ntlv_pkg::VAL_W-1:0]   remain_dec;
    logic [ntlv_pkg::LEVEL_W-1:0] open_inc, open_dec;

    // depth limit clamped to the supported range
    always_comb begin
        eff_limit = depth_limit_reg;
        if (eff_limit == '0) begin
            eff_limit = ntlv_pkg::LIM_W'(1);
        end
        if (32'(eff_limit) > ntlv_pkg::MAX_DEPTH) begin
            eff_limit = ntlv_pkg::LIM_W'(ntlv_pkg::MAX_DEPTH);
        end
    end

    // byte lane placement, little endian
    assign idl        = byte_i[7:4];
    assign szl        = byte_i[3:0];
    assign idx_inc    = byte_idx_reg + 4'd1;
    assign byte_shift = ntlv_pkg::VAL_W'(byte_i) << {byte_idx_reg[2:0], 3'b000};
    assign tag_merged = tag_acc_reg | byte_shift;
    assign len_merged = len_acc_reg | byte_shift;
    assign remain_dec = remain_reg - ntlv_pkg::VAL_W'(1);
    assign open_inc   = open_reg + ntlv_pkg::LEVEL_W'(1);
    assign open_dec   = open_reg - ntlv_pkg::LEVEL_W'(1);

    // next state and event for the beat at hand
    always_comb begin
        phase_next    = phase_reg;
        tag_len_next  = tag_len_reg;
        len_len_next  = len_len_reg;
        byte_idx_next = byte_idx_reg;
        tag_acc_next  = tag_acc_reg;
        len_acc_next  = len_acc_reg;
        remain_next   = remain_reg;
        open_next     = open_reg;
        ev            = '0;
        unique case (phase_reg)
            ntlv_pkg::PH_HEADER: begin
                if (idl == 4'd0) begin
                    ev.valid = 1'b1;
                    if (open_reg != '0) begin
                        open_next = open_dec;
                        ev.kind   = ntlv_pkg::EV_END;
                        ev.level  = open_dec;
                    end else begin
                        ev.kind = ntlv_pkg::EV_STRAY;
                    end
                end else if (idl > ntlv_pkg::MAX_FIELD_LEN || szl > ntlv_pkg::MAX_FIELD_LEN
                             || open_reg >= eff_limit) begin
                    phase_next = ntlv_pkg::PH_ERROR;
                    ev.valid   = 1'b1;
                    ev.kind    = ntlv_pkg::EV_ERROR;
                end else begin
                    tag_len_next  = idl;
                    len_len_next  = szl;
                    byte_idx_next = 4'd0;
                    tag_acc_next  = '0;
                    len_acc_next  = '0;
                    phase_next    = ntlv_pkg::PH_TAG;
                end
            end
            ntlv_pkg::PH_TAG: begin
                tag_acc_next  = tag_merged;
                byte_idx_next = idx_inc;
                if (idx_inc >= tag_len_reg) begin
                    byte_idx_next = 4'd0;
                    if (len_len_reg != 4'd0) begin
                        phase_next = ntlv_pkg::PH_LEN;
                    end else begin
                        // node without size bytes starts with zero length
                        open_next   = open_inc;
                        remain_next = len_acc_reg;
                        phase_next  = (len_acc_reg != '0) ? ntlv_pkg::PH_DATA
                                                          : ntlv_pkg::PH_HEADER;
                        ev.valid    = 1'b1;
                        ev.kind     = ntlv_pkg::EV_START;
                        ev.tag      = tag_merged;
                        ev.length   = len_acc_reg;
                        ev.level    = open_reg;
                    end
                end
            end
            ntlv_pkg::PH_LEN: begin
                len_acc_next  = len_merged;
                byte_idx_next = idx_inc;
                if (idx_inc >= len_len_reg) begin
                    byte_idx_next = 4'd0;
                    open_next     = open_inc;
                    remain_next   = len_merged;
                    phase_next    = (len_merged != '0) ? ntlv_pkg::PH_DATA
                                                       : ntlv_pkg::PH_HEADER;
                    ev.valid      = 1'b1;
                    ev.kind       = ntlv_pkg::EV_START;
                    ev.tag        = tag_acc_reg;
                    ev.length     = len_merged;
                    ev.level      = open_reg;
                end
            end
            ntlv_pkg::PH_DATA: begin
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    phase_next = ntlv_pkg::PH_HEADER;
                end
                ev.valid = 1'b1;
                ev.kind  = ntlv_pkg::EV_DATA;
                ev.level = (open_reg != '0) ? open_dec : '0;
                ev.data  = byte_i;
            end
            default: begin
                // error phase swallows every beat
            end
        endcase
    end

    // depth limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_limit_reg <= ntlv_pkg::DEPTH_LIMIT_RST;
        end else if (cfg_we) begin
            depth_limit_reg <= cfg_wdata;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= ntlv_pkg::PH_HEADER;
            tag_len_reg  <= '0;
            len_len_reg  <= '0;
            byte_idx_reg <= '0;
            tag_acc_reg  <= '0;
            len_acc_reg  <= '0;
            remain_reg   <= '0;
            open_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            tag_len_reg  <= tag_len_next;
            len_len_reg  <= len_len_next;
            byte_idx_reg <= byte_idx_next;
            tag_acc_reg  <= tag_acc_next;
            len_acc_reg  <= len_acc_next;
            remain_reg   <= remain_next;
            open_reg     <= open_next;
        end
    end

    // checks
    `NTLV_ASSERT_NEXT(a_error_sticky, phase_reg == ntlv_pkg::PH_ERROR, phase_reg == ntlv_pkg::PH_ERROR, "error phase left")
    `NTLV_ASSERT_NEXT(a_error_enters_phase, step && ev.valid && ev.kind == ntlv_pkg::EV_ERROR, phase_reg == ntlv_pkg::PH_ERROR, "error event without error phase")
    `NTLV_ASSERT(a_data_remaining, phase_reg != ntlv_pkg::PH_DATA || remain_reg != '0, "data phase with nothing left")
    `NTLV_ASSERT(a_data_emits, !(step && phase_reg == ntlv_pkg::PH_DATA) || (ev.valid && ev.kind == ntlv_pkg::EV_DATA), "data beat without data event")

endmodule

// ===== src/nested_tlv_stream_parser.sv =====
// Nested tag-length-value stream parser. One stream byte enters per beat
// and yields at most one event beat (node start, data byte, node end, stray
// end marker or error). Throughput is one byte per clock unless a result
// waits on m_tready, which holds up the next byte, even one that gives no
// event. The header decode, the little-endian identifier and size
// accumulators and the payload countdown all work combinationally between
// the input register and the result register, which holds the event beat.
// Only the last identifier or size byte of a header gives an event, the
// node start. After an error event the block ignores all input until reset.
// depth_limit may be written only while no beat is in flight.
// depends on ntlv_pkg, ntlv_in_stage and ntlv_core
`timescale 1ns / 1ps

module nested_tlv_stream_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [ntlv_pkg::LIM_W-1:0]    cfg_wdata,    // depth_limit
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ntlv_pkg::BYTE_W-1:0]   s_tdata,      // stream_byte
    // event beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // node_tag [63:0], payload_length [127:64], nesting_level [131:128],
    // payload_byte [139:132], zero pad [143:140]
    output logic [ntlv_pkg::TDATA_W-1:0]  m_tdata,
    output logic [ntlv_pkg::KIND_W-1:0]   m_tuser       // event_kind
);

    localparam int unsigned PAY_W = 2 * ntlv_pkg::VAL_W + ntlv_pkg::LEVEL_W
                                    + ntlv_pkg::BYTE_W;

    logic                        hold_valid;
    logic [ntlv_pkg::BYTE_W-1:0] hold_byte;
    logic                        step;
    ntlv_pkg::event_t            ev;

    logic                        out_valid_reg;
    logic [ntlv_pkg::KIND_W-1:0] out_kind_reg;
    logic [PAY_W-1:0]            out_pay_reg;

    // held beat moves on when the result slot is free
    assign step = hold_valid && (!out_valid_reg || m_tready);

    ntlv_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (step),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    ntlv_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_i    (hold_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ev        (ev)
    );

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= ev.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (step && ev.valid) begin
            out_kind_reg <= ev.kind;
            out_pay_reg  <= {ev.data, ev.level, ev.length, ev.tag};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = ntlv_pkg::TDATA_W'(out_pay_reg);

endmodule
